FILE: hdl/vmc_pkg.sv
// vmc_pkg: shared types, constants and widths for the vector magnitude clamp unit.
// Used by vector_magnitude_clamp_unit and its testbench. No dependencies.
package vmc_pkg;
    localparam int COMP_WIDTH_DEF = 16;
    localparam int LEN_WIDTH      = 16;
    localparam int HIT_WIDTH      = 2;
    localparam int CFG_IDX_WIDTH  = 1;

    localparam logic [HIT_WIDTH-1:0] HIT_NONE = 2'd0;
    localparam logic [HIT_WIDTH-1:0] HIT_MIN  = 2'd1;
    localparam logic [HIT_WIDTH-1:0] HIT_MAX  = 2'd2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_LENGTH = 1'd1;

    localparam logic [LEN_WIDTH-1:0] MIN_LENGTH_RST = 16'd0;
    localparam logic [LEN_WIDTH-1:0] MAX_LENGTH_RST = 16'd46341;
endpackage

FILE: hdl/vmc_sqrt_cell.sv
// vmc_sqrt_cell: one digit-recurrence step of the integer square root.
// Registered; passes the partial root and remainder on. Depends on nothing.
module vmc_sqrt_cell #(
    parameter int SQ_W = 33,
    parameter int RT_W = 17,
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [SQ_W-1:0] rem_in,
    input  logic [RT_W-1:0] root_in,
    output logic [SQ_W-1:0] rem_out,
    output logic [RT_W-1:0] root_out
);
    localparam int SH = 2 * (RT_W - 1 - STEP);

    logic [SQ_W+1:0] trial;
    logic [SQ_W+1:0] rem_ext;
    logic [SQ_W-1:0] rem_next;
    logic [RT_W-1:0] root_next;

    // trial = (4*root + 1) << SH; root holds only bits already decided
    always_comb
    begin
        trial   = (({{(SQ_W+2-RT_W){1'b0}}, root_in} << 2) | {{(SQ_W+1){1'b0}}, 1'b1}) << SH;
        rem_ext = {2'b00, rem_in};
        if (rem_ext >= trial)
        begin
            rem_next  = SQ_W'(rem_ext - trial);
            root_next = {root_in[RT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_in;
            root_next = {root_in[RT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_out  <= '0;
            root_out <= '0;
        end
        else if (en)
        begin
            rem_out  <= rem_next;
            root_out <= root_next;
        end
    end
endmodule

FILE: hdl/vmc_div_cell.sv
// vmc_div_cell: one restoring-division step on two lanes sharing a divisor.
// Registered; shifts one quotient bit in per lane. Depends on nothing.
module vmc_div_cell #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [DEN_W-1:0] den,
    input  logic [DEN_W:0]   rem_a_in,
    input  logic [NUM_W-1:0] num_a_in,
    input  logic [DEN_W:0]   rem_b_in,
    input  logic [NUM_W-1:0] num_b_in,
    output logic [DEN_W:0]   rem_a_out,
    output logic [NUM_W-1:0] num_a_out,
    output logic [DEN_W:0]   rem_b_out,
    output logic [NUM_W-1:0] num_b_out
);
    logic [DEN_W+1:0] sa, sb;
    logic [DEN_W:0]   ra, rb;
    logic             qa, qb;

    always_comb
    begin
        sa = {rem_a_in, num_a_in[NUM_W-1]};
        sb = {rem_b_in, num_b_in[NUM_W-1]};
        qa = (sa >= {1'b0, 1'b0, den});
        qb = (sb >= {1'b0, 1'b0, den});
        ra = qa ? (DEN_W+1)'(sa - {2'b00, den}) : sa[DEN_W:0];
        rb = qb ? (DEN_W+1)'(sb - {2'b00, den}) : sb[DEN_W:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_a_out <= '0;
            num_a_out <= '0;
            rem_b_out <= '0;
            num_b_out <= '0;
        end
        else if (en)
        begin
            rem_a_out <= ra;
            num_a_out <= {num_a_in[NUM_W-2:0], qa};
            rem_b_out <= rb;
            num_b_out <= {num_b_in[NUM_W-2:0], qb};
        end
    end
endmodule

FILE: hdl/vector_magnitude_clamp_unit.sv
// vector_magnitude_clamp_unit: clamps a 2D vector's length between two limits.
// Throughput one item per cycle whenever the pipeline is not stalled.
// Pipeline: squares and limit products, compare and select, then a row of isqrt
// cells, then a row of divider cells, then saturation into the output register.
// The whole pipeline stalls only when the output register is full and not taken.
// Reset (rst_n, async low) clears all valid bits and loads the default limits.
module vector_magnitude_clamp_unit #(
    parameter int COMP_WIDTH = vmc_pkg::COMP_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [vmc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [vmc_pkg::LEN_WIDTH-1:0]     cfg_data,
    // input items
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [2*COMP_WIDTH-1:0]   s_tdata,  // vec_x, vec_y
    // result items
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [2*COMP_WIDTH-1:0]   m_tdata,  // out_x, out_y
    output logic [vmc_pkg::HIT_WIDTH-1:0] m_tuser // limit_hit
);
    localparam int LW    = vmc_pkg::LEN_WIDTH;
    localparam int SQ_W  = 2 * COMP_WIDTH + 1;       // x^2 + y^2
    localparam int RT_W  = COMP_WIDTH + 1;           // isqrt of SQ_W
    localparam int NUM_W = COMP_WIDTH + LW;          // |c| * lim
    localparam int NRT   = RT_W;                     // sqrt cells
    localparam int NDV   = NUM_W;                    // divider cells

    logic [LW-1:0] min_len_reg, max_len_reg;
    logic          adv;

    // whole pipeline moves when output slot is free or being emptied
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= vmc_pkg::MIN_LENGTH_RST;
            max_len_reg <= vmc_pkg::MAX_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                vmc_pkg::REG_MIN_LENGTH: min_len_reg <= cfg_data;
                vmc_pkg::REG_MAX_LENGTH: max_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: magnitudes, squares of components and limits, and |c| times both limits in parallel
    logic signed [COMP_WIDTH-1:0] vx, vy;
    logic [COMP_WIDTH-1:0]        ax, ay;
    assign vx = s_tdata[COMP_WIDTH-1:0];
    assign vy = s_tdata[2*COMP_WIDTH-1:COMP_WIDTH];
    assign ax = vx[COMP_WIDTH-1] ? COMP_WIDTH'(-vx) : vx;
    assign ay = vy[COMP_WIDTH-1] ? COMP_WIDTH'(-vy) : vy;

    logic                  v1_reg;
    logic [COMP_WIDTH-1:0] x1_reg, y1_reg;
    logic [2*COMP_WIDTH-1:0] sx1_reg, sy1_reg;
    logic [2*LW-1:0]       mn1_reg, mx1_reg;
    logic [NUM_W-1:0]      pamn1_reg, pamx1_reg, pbmn1_reg, pbmx1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg    <= vx;
            y1_reg    <= vy;
            sx1_reg   <= ax * ax;
            sy1_reg   <= ay * ay;
            mn1_reg   <= min_len_reg * min_len_reg;
            mx1_reg   <= max_len_reg * max_len_reg;
            pamn1_reg <= ax * min_len_reg;
            pamx1_reg <= ax * max_len_reg;
            pbmn1_reg <= ay * min_len_reg;
            pbmx1_reg <= ay * max_len_reg;
        end
    end

    // stage 2: sum and compares, pick the scaled numerators
    logic [SQ_W-1:0] sq2;
    logic [vmc_pkg::HIT_WIDTH-1:0] hit2;
    logic [NUM_W-1:0] pa2, pb2;
    localparam int CW = (SQ_W > 2*LW) ? SQ_W : 2*LW;

    always_comb
    begin
        sq2  = {1'b0, sx1_reg} + {1'b0, sy1_reg};
        hit2 = vmc_pkg::HIT_NONE;
        pa2  = '0;
        pb2  = '0;
        if (sq2 != '0)
        begin
            if (CW'(sq2) < CW'(mn1_reg))
            begin
                hit2 = vmc_pkg::HIT_MIN;
                pa2  = pamn1_reg;
                pb2  = pbmn1_reg;
            end
            else if (CW'(sq2) > CW'(mx1_reg))
            begin
                hit2 = vmc_pkg::HIT_MAX;
                pa2  = pamx1_reg;
                pb2  = pbmx1_reg;
            end
        end
    end

    logic                  v2_reg;
    logic [COMP_WIDTH-1:0] x2_reg, y2_reg;
    logic [SQ_W-1:0]       sq2_reg;
    logic [vmc_pkg::HIT_WIDTH-1:0] hit2_reg;
    logic [NUM_W-1:0]      pa2_reg, pb2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            sq2_reg  <= sq2;
            hit2_reg <= hit2;
            pa2_reg  <= pa2;
            pb2_reg  <= pb2;
        end
    end

    // isqrt row; side data rides along in shift lines
    logic [SQ_W-1:0]  rt_rem  [0:NRT];
    logic [RT_W-1:0]  rt_root [0:NRT];
    assign rt_rem[0]  = sq2_reg;
    assign rt_root[0] = '0;

    for (genvar i = 0; i < NRT; i++)
    begin : g_sqrt
        vmc_sqrt_cell #(.SQ_W(SQ_W), .RT_W(RT_W), .STEP(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .rem_in   (rt_rem[i]),
            .root_in  (rt_root[i]),
            .rem_out  (rt_rem[i+1]),
            .root_out (rt_root[i+1])
        );
    end

    localparam int SD_W = 1 + 2*COMP_WIDTH + vmc_pkg::HIT_WIDTH + 2*NUM_W;
    logic [SD_W-1:0] sd_reg [0:NRT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NRT; i++)
                sd_reg[i] <= '0;
        end
        else if (adv)
        begin
            sd_reg[0] <= {v2_reg, x2_reg, y2_reg, hit2_reg, pa2_reg, pb2_reg};
            for (int i = 1; i < NRT; i++)
                sd_reg[i] <= sd_reg[i-1];
        end
    end

    // divider row: quotient bits for both lanes, root as shared divisor
    logic [RT_W-1:0]  den;
    logic [RT_W:0]    dra [0:NDV];
    logic [RT_W:0]    drb [0:NDV];
    logic [NUM_W-1:0] dna [0:NDV];
    logic [NUM_W-1:0] dnb [0:NDV];
    logic [RT_W-1:0]  den_reg [0:NDV-1];

    assign den    = rt_root[NRT];
    assign dra[0] = '0;
    assign drb[0] = '0;
    assign dna[0] = sd_reg[NRT-1][2*NUM_W-1:NUM_W];
    assign dnb[0] = sd_reg[NRT-1][NUM_W-1:0];

    localparam int DS_W = 1 + 2*COMP_WIDTH + vmc_pkg::HIT_WIDTH;
    logic [DS_W-1:0] ds_reg [0:NDV-1];

    for (genvar i = 0; i < NDV; i++)
    begin : g_div
        vmc_div_cell #(.NUM_W(NUM_W), .DEN_W(RT_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .den       ((i == 0) ? den : den_reg[(i == 0) ? 0 : i-1]),
            .rem_a_in  (dra[i]),
            .num_a_in  (dna[i]),
            .rem_b_in  (drb[i]),
            .num_b_in  (dnb[i]),
            .rem_a_out (dra[i+1]),
            .num_a_out (dna[i+1]),
            .rem_b_out (drb[i+1]),
            .num_b_out (dnb[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NDV; i++)
            begin
                ds_reg[i]  <= '0;
                den_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            ds_reg[0]  <= sd_reg[NRT-1][SD_W-1:2*NUM_W];
            den_reg[0] <= den;
            for (int i = 1; i < NDV; i++)
            begin
                ds_reg[i]  <= ds_reg[i-1];
                den_reg[i] <= den_reg[i-1];
            end
        end
    end

    // final: sign, saturation, output register
    logic                  fv;
    logic [COMP_WIDTH-1:0] fx, fy;
    logic [vmc_pkg::HIT_WIDTH-1:0] fhit;
    logic [COMP_WIDTH-1:0] ox, oy;

    assign fv   = ds_reg[NDV-1][DS_W-1];
    assign fx   = ds_reg[NDV-1][DS_W-2 -: COMP_WIDTH];
    assign fy   = ds_reg[NDV-1][DS_W-2-COMP_WIDTH -: COMP_WIDTH];
    assign fhit = ds_reg[NDV-1][vmc_pkg::HIT_WIDTH-1:0];

    function automatic logic [COMP_WIDTH-1:0] sat_comp(
        input logic            neg,
        input logic [NUM_W-1:0] q
    );
        logic [NUM_W-1:0] lim_pos;
        logic [NUM_W-1:0] lim_neg;
        logic [NUM_W-1:0] qs;
        lim_pos = NUM_W'({1'b0, {(COMP_WIDTH-1){1'b1}}});
        lim_neg = lim_pos + NUM_W'(1);
        if (neg)
        begin
            qs = (q > lim_neg) ? lim_neg : q;
            sat_comp = COMP_WIDTH'(-qs);
        end
        else
        begin
            qs = (q > lim_pos) ? lim_pos : q;
            sat_comp = qs[COMP_WIDTH-1:0];
        end
    endfunction

    always_comb
    begin
        if (fhit != vmc_pkg::HIT_NONE)
        begin
            ox = sat_comp(fx[COMP_WIDTH-1], dna[NDV]);
            oy = sat_comp(fy[COMP_WIDTH-1], dnb[NDV]);
        end
        else
        begin
            ox = fx;
            oy = fy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (adv)
            m_tvalid <= fv;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata <= {oy, ox};
            m_tuser <= fhit;
        end
    end
endmodule

FILE: dv/vector_magnitude_clamp_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for vector_magnitude_clamp_unit: directed and random vectors under several
// length limits, with a behavioral limiter that predicts every result item.
// Depends on vmc_pkg and the RTL in hdl/.
module vector_magnitude_clamp_unit_tb;
    localparam int CW = vmc_pkg::COMP_WIDTH_DEF;
    localparam int LW = vmc_pkg::LEN_WIDTH;
    localparam int PIPE_DEPTH = 3 + (CW + 1) + (2 * CW + 16) + 4;

    typedef struct packed {
        logic [vmc_pkg::HIT_WIDTH-1:0] hit;
        logic [CW-1:0]        y;
        logic [CW-1:0]        x;
    } clamp_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [vmc_pkg::CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [LW-1:0]            cfg_data = '0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [2*CW-1:0]      s_tdata = '0;   // vec_x, vec_y
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [2*CW-1:0]      m_tdata;        // out_x, out_y
    logic [vmc_pkg::HIT_WIDTH-1:0] m_tuser; // limit_hit

    // predictor copy of the limit registers
    logic [LW-1:0] cur_min = vmc_pkg::MIN_LENGTH_RST;
    logic [LW-1:0] cur_max = vmc_pkg::MAX_LENGTH_RST;

    clamp_result_t clamped_q[$];
    int  err_count = 0;
    int  item_count = 0;
    int  result_count = 0;
    int  hit_count[3] = '{0, 0, 0};
    bit  idle_on = 1'b1;

    vector_magnitude_clamp_unit #(.COMP_WIDTH(CW)) DUT (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n)
                r = r | (64'd1 << b);
        end
        return r;
    endfunction

    // trunc(c * lim / root), saturated to the component range
    function automatic logic [CW-1:0] scale_component(logic signed [CW-1:0] c,
                                                      longint unsigned lim,
                                                      longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        mag = (c < 0) ? longint'(-longint'(c)) : longint'(c);
        q = (mag * lim) / root;
        if (c < 0)
        begin
            if (q > (64'd1 << (CW - 1)))
                q = 64'd1 << (CW - 1);
            return CW'(-longint'(q));
        end
        if (q > (64'd1 << (CW - 1)) - 1)
            q = (64'd1 << (CW - 1)) - 1;
        return CW'(q);
    endfunction

    function automatic clamp_result_t clamp_vector(logic signed [CW-1:0] x,
                                                   logic signed [CW-1:0] y);
        clamp_result_t r;
        longint unsigned ax, ay, sq, lim, root;
        ax = (x < 0) ? longint'(-longint'(x)) : longint'(x);
        ay = (y < 0) ? longint'(-longint'(y)) : longint'(y);
        sq = ax * ax + ay * ay;
        r.x = x;
        r.y = y;
        r.hit = vmc_pkg::HIT_NONE;
        lim = 0;
        if (sq != 0)
        begin
            if (sq < longint'(cur_min) * cur_min)
            begin
                r.hit = vmc_pkg::HIT_MIN;
                lim = cur_min;
            end
            else if (sq > longint'(cur_max) * cur_max)
            begin
                r.hit = vmc_pkg::HIT_MAX;
                lim = cur_max;
            end
        end
        if (r.hit != vmc_pkg::HIT_NONE)
        begin
            root = floor_sqrt(sq);
            r.x = scale_component(x, lim, root);
            r.y = scale_component(y, lim, root);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        err_count++;
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // valid drops only while idling
    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    // sends one item; expectation is queued at acceptance
    task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y);
        idle_gap();
        s_tdata  <= {y, x};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        clamped_q.push_back(clamp_vector(x, y));
        item_count++;
        @(negedge clk);
    endtask

    // only called with the pipeline drained
    task automatic write_limit(logic [vmc_pkg::CFG_IDX_WIDTH-1:0] idx, logic [LW-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == vmc_pkg::REG_MIN_LENGTH)
            cur_min = val;
        else
            cur_max = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (clamped_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH) @(negedge clk);
    endtask

    task automatic set_limits(logic [LW-1:0] lo, logic [LW-1:0] hi);
        drain();
        write_limit(vmc_pkg::REG_MIN_LENGTH, lo);
        write_limit(vmc_pkg::REG_MAX_LENGTH, hi);
    endtask

    // random receiver stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // result checker
    initial
    begin
        clamp_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (clamped_q.size() == 0)
                    report_mismatch("result with nothing expected, out_x", m_tdata[CW-1:0], 0);
                else
                begin
                    want = clamped_q.pop_front();
                    result_count++;
                    hit_count[want.hit]++;
                    if (m_tdata[CW-1:0] !== want.x)
                        report_mismatch("out_x", $signed(m_tdata[CW-1:0]), $signed(want.x));
                    if (m_tdata[2*CW-1:CW] !== want.y)
                        report_mismatch("out_y", $signed(m_tdata[2*CW-1:CW]),
                                        $signed(want.y));
                    if (m_tuser !== want.hit)
                        report_mismatch("limit_hit", m_tuser, want.hit);
                end
            end
        end
    end

    // extremes, zero vector, axis and diagonal cases under reset limits
    task automatic test_directed();
        logic [CW-1:0] ends[6] = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        send_vector(16'h0000, 16'h0000);
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h7FFF, 16'h7FFF);
        send_vector(16'h8000, 16'h0000);
        for (int i = 0; i < 6; i++)
            send_vector(ends[i], ends[5 - i]);
    endtask

    // raise-to-minimum, min above max, saturation, zero vector with nonzero minimum
    task automatic test_limit_cases();
        set_limits(16'd1000, 16'd2000);
        send_vector(16'd3, 16'd4);
        send_vector(16'h0000, 16'h0000);
        send_vector(-16'sd600, 16'd800);
        send_vector(16'd30000, -16'sd30000);
        send_vector(16'd1000, 16'd0);
        send_vector(16'd2000, 16'd0);
        set_limits(16'd46341, 16'd10);
        send_vector(16'd1, 16'd0);
        send_vector(16'h8000, 16'h0000);
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h0001, 16'hFFFF);
        set_limits(16'hFFFF, 16'hFFFF);
        send_vector(16'd1, 16'd0);
        send_vector(16'hFFFF, 16'h0000);
        set_limits(16'd0, 16'd0);
        send_vector(16'd5, 16'hFFFB);
        send_vector(16'h0000, 16'h0000);
    endtask

    task automatic random_vector();
        logic [CW-1:0] x, y;
        int shift;
        shift = $urandom_range(0, CW - 1);
        x = CW'($urandom() >> shift);
        y = CW'($urandom() >> $urandom_range(0, CW - 1));
        if ($urandom_range(0, 1)) x = -x;
        if ($urandom_range(0, 1)) y = -y;
        if ($urandom_range(0, 9) == 0) x = CW'($urandom());
        send_vector(x, y);
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            set_limits(LW'($urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom()),
                       LW'($urandom_range(0, 1) ? $urandom_range(0, 50000) : $urandom()));
            for (int i = 0; i < per_phase; i++)
                random_vector();
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_limit_cases();
        test_random(10, 100);
        idle_on = 1'b0;
        test_random(3, 100);
        drain();
        $display("%0d vectors, %0d results: %0d unchanged, %0d raised, %0d lowered",
                 item_count, result_count, hit_count[0], hit_count[1], hit_count[2]);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: sim.f
hdl/vmc_pkg.sv
hdl/vmc_sqrt_cell.sv
hdl/vmc_div_cell.sv
hdl/vector_magnitude_clamp_unit.sv
dv/vector_magnitude_clamp_unit_tb.sv
